@@ design/servo_pulse_ramp_assert.svh @@
`ifndef SERVO_PULSE_RAMP_ASSERT_SVH
`define SERVO_PULSE_RAMP_ASSERT_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define SPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define SPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/spr_pkg.sv @@
package spr_pkg;

  // Field and register widths.
  localparam int unsigned PULSE_W    = 16;
  localparam int unsigned ANGLE_W    = 12;
  localparam int unsigned SLEW_W     = 8;
  localparam int unsigned HOLD_W     = 8;
  localparam int unsigned SPD_W      = 4;
  localparam int unsigned TICKS_W    = 16;
  localparam int unsigned STEP_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // The serial unit: multiplier digits and quotient bits per operation.
  localparam int unsigned QUO_W  = PULSE_W;
  localparam int unsigned MPL_W  = PULSE_W;
  localparam int unsigned PROD_W = PULSE_W + ANGLE_W;
  localparam int unsigned CNT_W  = $clog2(QUO_W);

  // Reset values.
  localparam logic [PULSE_W-1:0] RESET_PULSE     = 16'd1500;
  localparam logic [PULSE_W-1:0] RST_MIN_PULSE   = 16'd500;
  localparam logic [PULSE_W-1:0] RST_MAX_PULSE   = 16'd2500;
  localparam logic [ANGLE_W-1:0] RST_MAX_ANGLE   = 12'd2880;
  localparam logic [SLEW_W-1:0]  RST_SLEW_STEP   = 8'd3;
  localparam logic [HOLD_W-1:0]  RST_SOFT_HOLD   = 8'd5;
  localparam logic [SPD_W-1:0]   RST_SOFT_SPD    = 4'd4;

  typedef enum logic [1:0] {
    REQ_TICK,
    REQ_SET,
    REQ_SMOOTH,
    REQ_SOFT
  } req_e;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_UP,
    MODE_DOWN,
    MODE_SOFT
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_PULSE = 3'd0,
    CFG_MAX_PULSE = 3'd1,
    CFG_MAX_ANGLE = 3'd2,
    CFG_SLEW_STEP = 3'd3,
    CFG_SOFT_HOLD = 3'd4,
    CFG_SOFT_SPD  = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANG_MUL,
    ST_ANG_DIV,
    ST_SS_XMUL,
    ST_SS_YMUL,
    ST_SS_DIFF,
    ST_SS_DIV,
    ST_SP_DEN,
    ST_SP_XMUL,
    ST_SP_YMUL,
    ST_SP_SMUL,
    ST_SP_AMUL,
    ST_SP_DIV,
    ST_WB
  } seq_state_e;

endpackage

@@ design/servo_pulse_ramp.sv @@
// Channel  Dir  Handshake                  Word
// in       in   in_valid_i / in_stall_o    req_type_i, target_angle_i, step_ticks_i
// out      out  out_valid_o / out_stall_i  pulse_value_o, busy_res_o, done_res_o
// cfg      in   cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One word at a time. A tick without arithmetic or any word with a degenerate range goes
// straight to write-back; set and smooth requests take a multiply and a divide; a soft
// start, two multiplies, a difference step and a divide; a tick that moves a soft start
// on, five multiplies and one divide: the shared bit-serial unit, one bit per cycle.
// Reset loads the register reset values and the 1500 pulse; the block is ready at once.
// A stalled result waits in the output register while the next word is accepted and
// worked; that word then waits in write-back until the output register frees up.

`include "servo_pulse_ramp_assert.svh"

module servo_pulse_ramp import spr_pkg::*; #(
  parameter int unsigned ANGLE_FRAC_BITS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration writes.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Request and tick words.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            req_type_i,
  input  logic [ANGLE_W-1:0]    target_angle_i,
  input  logic [TICKS_W-1:0]    step_ticks_i,
  // Result words.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PULSE_W-1:0]    pulse_value_o,
  output logic                  busy_res_o,
  output logic                  done_res_o
);

  localparam int unsigned SHDEN_W = PULSE_W + ANGLE_FRAC_BITS;
  localparam int unsigned DEN_W   = (PROD_W > SHDEN_W) ? PROD_W : SHDEN_W;
  localparam int unsigned REM_W   = DEN_W + 1;
  localparam int unsigned ACC_W   = QUO_W + REM_W;

  // Configuration registers.
  logic [PULSE_W-1:0] min_pulse_q, max_pulse_q;
  logic [ANGLE_W-1:0] max_angle_q;
  logic [SLEW_W-1:0]  slew_step_q;
  logic [HOLD_W-1:0]  soft_hold_q;
  logic [SPD_W-1:0]   soft_spd_q;

  // Ramp state.
  logic [PULSE_W-1:0] pulse_now_q, pulse_d;
  logic [PULSE_W-1:0] ramp_start_q, start_d;
  logic [PULSE_W-1:0] ramp_target_q, target_d;
  mode_e              mode_q, mode_d;
  logic [TICKS_W-1:0] hold_left_q, hold_left_d;
  logic [TICKS_W-1:0] hold_len_q, hold_len_d;
  logic [STEP_W-1:0]  step_index_q, index_d;
  logic [STEP_W-1:0]  step_count_q, count_d;
  logic               done_d;

  // Sequencer and latched word.
  seq_state_e         state_q, state_d;
  req_e               req_q;
  logic [ANGLE_W-1:0] t_q;
  logic [TICKS_W-1:0] st_q;
  logic               in_accept, commit, iter_last, div_state;

  // Serial multiply/divide unit.
  logic [ACC_W-1:0]   acc_q, mcand_q, acc_sum, div_next;
  logic [MPL_W-1:0]   mpl_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [PROD_W-1:0]  x_q;
  logic [DEN_W-1:0]   den_q;
  logic [REM_W-1:0]   rem_shift, rem_sub, den_ext;
  logic               div_ge;

  // Output register.
  logic               out_valid_q;
  logic [PULSE_W-1:0] out_pulse_q;
  logic               out_busy_q, out_done_q;

  // Derived values.
  logic [PULSE_W-1:0]       span, a_raw, a_now, a_sp, slew, pa, quo;
  logic                     degen;
  logic [ANGLE_W-1:0]       t_clamp, tc;
  logic [STEP_W-1:0]        soft_n, i_next;
  logic [TICKS_W-1:0]       hold_dec;
  logic [PULSE_W:0]         up_next, smooth_lim;
  logic [PULSE_W+1:0]       down_lim;
  logic [QUO_W+SPD_W-1:0]   steps_full;
  logic [STEP_W-1:0]        steps;
  logic                     tick_arith;
  logic [PROD_W-1:0]        xy_diff;

  // Span, clamped angles and start points.
  always_comb begin
    span    = (max_pulse_q > min_pulse_q) ? max_pulse_q - min_pulse_q : '0;
    degen   = (span == '0) || (max_angle_q == '0);
    t_clamp = (target_angle_i > max_angle_q) ? max_angle_q : target_angle_i;
    a_raw   = (pulse_now_q > min_pulse_q) ? pulse_now_q - min_pulse_q : '0;
    a_now   = (a_raw > span) ? span : a_raw;
    a_sp    = (ramp_start_q > span) ? span : ramp_start_q;
    tc      = (ramp_target_q > PULSE_W'(max_angle_q)) ? max_angle_q
                                                      : ramp_target_q[ANGLE_W-1:0];
    soft_n  = (step_count_q != '0) ? step_count_q : STEP_W'(1);
    i_next  = step_index_q + STEP_W'(1);
    slew    = (slew_step_q != '0) ? PULSE_W'(slew_step_q) : PULSE_W'(1);
    tick_arith = (mode_q == MODE_SOFT) && (hold_left_q <= TICKS_W'(1)) &&
                 (step_index_q < step_count_q) && !degen;
  end

  // Multiplier add, divider compare-subtract.
  always_comb begin
    acc_sum   = mpl_q[0] ? acc_q + mcand_q : acc_q;
    rem_shift = {acc_q[ACC_W-2:QUO_W], acc_q[QUO_W-1]};
    den_ext   = REM_W'(den_q);
    div_ge    = rem_shift >= den_ext;
    rem_sub   = div_ge ? rem_shift - den_ext : rem_shift;
    div_next  = {rem_sub, acc_q[QUO_W-2:0], div_ge};
    xy_diff   = (x_q > acc_q[PROD_W-1:0]) ? x_q - acc_q[PROD_W-1:0]
                                          : acc_q[PROD_W-1:0] - x_q;
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (req_e'(req_type_i))
            REQ_TICK:   state_d = tick_arith ? ST_SP_DEN : ST_WB;
            REQ_SOFT:   state_d = degen ? ST_WB : ST_SS_XMUL;
            default:    state_d = degen ? ST_WB : ST_ANG_MUL;
          endcase
        end
      end
      ST_ANG_MUL: if (iter_last) state_d = ST_ANG_DIV;
      ST_ANG_DIV: if (iter_last) state_d = ST_WB;
      ST_SS_XMUL: if (iter_last) state_d = ST_SS_YMUL;
      ST_SS_YMUL: if (iter_last) state_d = ST_SS_DIFF;
      ST_SS_DIFF: state_d = ST_SS_DIV;
      ST_SS_DIV:  if (iter_last) state_d = ST_WB;
      ST_SP_DEN:  if (iter_last) state_d = ST_SP_XMUL;
      ST_SP_XMUL: if (iter_last) state_d = ST_SP_YMUL;
      ST_SP_YMUL: if (iter_last) state_d = ST_SP_SMUL;
      ST_SP_SMUL: if (iter_last) state_d = ST_SP_AMUL;
      ST_SP_AMUL: if (iter_last) state_d = ST_SP_DIV;
      ST_SP_DIV:  if (iter_last) state_d = ST_WB;
      ST_WB:      if (commit) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    in_accept  = in_valid_i && (state_q == ST_IDLE);
    commit     = (state_q == ST_WB) && (!out_valid_q || !out_stall_i);
    iter_last  = (cnt_q == CNT_W'(QUO_W - 1));
    div_state  = (state_q == ST_ANG_DIV) || (state_q == ST_SS_DIV) ||
                 (state_q == ST_SP_DIV);
  end

  // Serial datapath: operand loads, one multiplier bit or quotient bit a cycle.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          req_q <= req_e'(req_type_i);
          t_q   <= t_clamp;
          st_q  <= step_ticks_i;
          acc_q <= '0;
          cnt_q <= '0;
          if (req_e'(req_type_i) == REQ_TICK) begin
            mcand_q <= ACC_W'(max_angle_q);
            mpl_q   <= soft_n;
          end else begin
            mcand_q <= ACC_W'(t_clamp);
            mpl_q   <= span;
          end
        end
      end
      ST_ANG_MUL, ST_SS_XMUL, ST_SS_YMUL, ST_SP_DEN,
      ST_SP_XMUL, ST_SP_YMUL, ST_SP_SMUL, ST_SP_AMUL: begin
        acc_q   <= acc_sum;
        mcand_q <= mcand_q << 1;
        mpl_q   <= mpl_q >> 1;
        cnt_q   <= cnt_q + CNT_W'(1);
        if (iter_last) begin
          cnt_q <= '0;
          case (state_q)
            ST_ANG_MUL: den_q <= DEN_W'(max_angle_q);
            ST_SS_XMUL: begin
              x_q     <= acc_sum[PROD_W-1:0];
              acc_q   <= '0;
              mcand_q <= ACC_W'(a_now);
              mpl_q   <= MPL_W'(max_angle_q);
            end
            ST_SP_DEN: begin
              den_q   <= acc_sum[DEN_W-1:0];
              acc_q   <= '0;
              mcand_q <= ACC_W'(max_angle_q);
              mpl_q   <= soft_n - i_next;
            end
            ST_SP_XMUL: begin
              x_q     <= acc_sum[PROD_W-1:0];
              acc_q   <= '0;
              mcand_q <= ACC_W'(tc);
              mpl_q   <= i_next;
            end
            ST_SP_YMUL: begin
              acc_q   <= '0;
              mcand_q <= acc_sum;
              mpl_q   <= span;
            end
            ST_SP_SMUL: begin
              mcand_q <= ACC_W'(x_q);
              mpl_q   <= a_sp;
            end
            default: ;
          endcase
        end
      end
      ST_SS_DIFF: begin
        acc_q <= ACC_W'(xy_diff);
        den_q <= DEN_W'(span) << ANGLE_FRAC_BITS;
        cnt_q <= '0;
      end
      ST_ANG_DIV, ST_SS_DIV, ST_SP_DIV: begin
        acc_q <= div_next;
        cnt_q <= cnt_q + CNT_W'(1);
      end
      default: ;
    endcase
  end

  // Write-back: the new ramp state and the result word.
  always_comb begin
    quo        = acc_q[QUO_W-1:0];
    pa         = degen ? min_pulse_q : min_pulse_q + quo;
    hold_dec   = (hold_left_q != '0) ? hold_left_q - TICKS_W'(1) : '0;
    up_next    = {1'b0, pulse_now_q} + (PULSE_W+1)'(slew);
    down_lim   = (PULSE_W+2)'(ramp_target_q) + (PULSE_W+2)'({slew, 1'b0});
    smooth_lim = {1'b0, pa} + (PULSE_W+1)'(slew);
    steps_full = quo * soft_spd_q;
    if (steps_full == '0) begin
      steps = STEP_W'(1);
    end else if (steps_full > (QUO_W+SPD_W)'({STEP_W{1'b1}})) begin
      steps = {STEP_W{1'b1}};
    end else begin
      steps = steps_full[STEP_W-1:0];
    end

    pulse_d     = pulse_now_q;
    start_d     = ramp_start_q;
    target_d    = ramp_target_q;
    mode_d      = mode_q;
    hold_left_d = hold_left_q;
    hold_len_d  = hold_len_q;
    index_d     = step_index_q;
    count_d     = step_count_q;
    done_d      = 1'b0;

    case (req_q)
      REQ_TICK: begin
        if (mode_q != MODE_IDLE) begin
          hold_left_d = hold_dec;
          if (hold_dec == '0) begin
            hold_left_d = hold_len_q;
            case (mode_q)
              MODE_UP: begin
                if (up_next <= {1'b0, ramp_target_q}) begin
                  pulse_d = up_next[PULSE_W-1:0];
                end else begin
                  done_d = 1'b1;
                end
              end
              MODE_DOWN: begin
                if ({2'b00, pulse_now_q} >= down_lim) begin
                  pulse_d = pulse_now_q - slew;
                end else begin
                  pulse_d = ramp_target_q;
                  done_d  = 1'b1;
                end
              end
              MODE_SOFT: begin
                if (step_index_q >= step_count_q) begin
                  done_d = 1'b1;
                end else begin
                  index_d = i_next;
                  pulse_d = pa;
                end
              end
              default: ;
            endcase
            if (done_d) begin
              mode_d      = MODE_IDLE;
              hold_left_d = '0;
            end
          end
        end
      end
      REQ_SET: begin
        pulse_d     = pa;
        mode_d      = MODE_IDLE;
        hold_left_d = '0;
      end
      REQ_SMOOTH: begin
        target_d    = pa;
        hold_len_d  = (st_q != '0) ? st_q : TICKS_W'(1);
        hold_left_d = hold_len_d;
        if (pulse_now_q < pa) begin
          mode_d = MODE_UP;
        end else if ({1'b0, pulse_now_q} >= smooth_lim) begin
          mode_d = MODE_DOWN;
        end else begin
          pulse_d     = pa;
          mode_d      = MODE_IDLE;
          hold_left_d = '0;
        end
      end
      REQ_SOFT: begin
        if (degen) begin
          pulse_d     = min_pulse_q;
          mode_d      = MODE_IDLE;
          hold_left_d = '0;
        end else begin
          start_d     = a_now;
          target_d    = PULSE_W'(t_q);
          count_d     = steps;
          index_d     = '0;
          hold_len_d  = (soft_hold_q != '0) ? TICKS_W'(soft_hold_q) : TICKS_W'(1);
          hold_left_d = hold_len_d;
          mode_d      = MODE_SOFT;
          pulse_d     = min_pulse_q + a_now;
        end
      end
      default: ;
    endcase
  end

  // Control state, ramp state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      pulse_now_q   <= RESET_PULSE;
      ramp_start_q  <= '0;
      ramp_target_q <= '0;
      mode_q        <= MODE_IDLE;
      hold_left_q   <= '0;
      hold_len_q    <= '0;
      step_index_q  <= '0;
      step_count_q  <= '0;
      min_pulse_q   <= RST_MIN_PULSE;
      max_pulse_q   <= RST_MAX_PULSE;
      max_angle_q   <= RST_MAX_ANGLE;
      slew_step_q   <= RST_SLEW_STEP;
      soft_hold_q   <= RST_SOFT_HOLD;
      soft_spd_q    <= RST_SOFT_SPD;
    end else begin
      state_q     <= state_d;
      out_valid_q <= commit | (out_valid_q & out_stall_i);
      if (commit) begin
        pulse_now_q   <= pulse_d;
        ramp_start_q  <= start_d;
        ramp_target_q <= target_d;
        mode_q        <= mode_d;
        hold_left_q   <= hold_left_d;
        hold_len_q    <= hold_len_d;
        step_index_q  <= index_d;
        step_count_q  <= count_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MIN_PULSE: min_pulse_q <= cfg_wdata_i[PULSE_W-1:0];
          CFG_MAX_PULSE: max_pulse_q <= cfg_wdata_i[PULSE_W-1:0];
          CFG_MAX_ANGLE: max_angle_q <= cfg_wdata_i[ANGLE_W-1:0];
          CFG_SLEW_STEP: slew_step_q <= cfg_wdata_i[SLEW_W-1:0];
          CFG_SOFT_HOLD: soft_hold_q <= cfg_wdata_i[HOLD_W-1:0];
          CFG_SOFT_SPD:  soft_spd_q  <= cfg_wdata_i[SPD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_pulse_q <= pulse_d;
      out_busy_q  <= (mode_d != MODE_IDLE);
      out_done_q  <= done_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pulse_value_o = out_pulse_q;
  assign busy_res_o    = out_busy_q;
  assign done_res_o    = out_done_q;

  // The partial remainder stays below the divisor through every divide.
  `SPR_ASSERT_NOW(a_div_rem, div_state, acc_q[ACC_W-1:QUO_W] < den_ext, "remainder overflow")
  // A committed word mirrors the ramp state it leaves behind.
  `SPR_ASSERT_NEXT(a_out_state, commit, (out_pulse_q == pulse_now_q) && (out_busy_q == (mode_q != MODE_IDLE)), "result differs from state")
  // A soft start never runs past its last point.
  `SPR_ASSERT_NOW(a_soft_index, mode_q == MODE_SOFT, (step_index_q <= step_count_q) && (step_count_q != '0), "soft index past count")
  // A finished ramp is never reported as still running.
  `SPR_ASSERT_NOW(a_done_busy, out_valid_o && done_res_o, !busy_res_o, "done and busy together")

endmodule
